// ----- hdl/i6flt_pkg.sv -----
// Shared types and constants for the IPv6 ingress filter with TCP/UDP checksum check.
// No dependencies; used by every module of the block.
`default_nettype none

package i6flt_pkg;

	// Packet geometry
	localparam int unsigned HEADER_BYTES         = 40;
	localparam int unsigned MIN_PACKET_BYTES     = HEADER_BYTES + 4;
	localparam int unsigned MAX_PACKET_BYTES_DEF = 65535;
	localparam int unsigned POS_W                = 17;

	// Header offsets
	localparam int unsigned OFS_NEXT_HEADER = 6;
	localparam int unsigned OFS_SUM_START   = 8;
	localparam int unsigned OFS_DST_START   = 24;
	localparam int unsigned OFS_PORT_HI     = 42;
	localparam int unsigned OFS_PORT_LO     = 43;

	// Protocol numbers and version
	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;
	localparam logic [3:0] IP_VERSION = 4'd6;

	// Configuration register map
	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W  = 64;
	localparam logic [CFG_INDEX_W-1:0] REG_LOCAL_ADDR_UPPER = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_LOCAL_ADDR_LOWER = 1'b1;

	typedef enum logic [2:0] {
		VERDICT_TCP      = 3'd0,
		VERDICT_UDP      = 3'd1,
		VERDICT_OTHER    = 3'd2,
		VERDICT_SHORT    = 3'd3,
		VERDICT_WRONG_DA = 3'd4,
		VERDICT_BAD_CKS  = 3'd5,
		VERDICT_OVERSIZE = 3'd6
	} verdict_t;

	typedef struct packed {
		verdict_t    verdict;
		logic [15:0] dst_port;
		logic [15:0] ul_len;
		logic [7:0]  protocol;
		logic [31:0] failures;
	} result_t;

endpackage

`default_nettype wire

// ----- hdl/i6flt_core.sv -----
// Per-byte parse state, running ones' complement sum and end-of-packet verdict.
// Depends on i6flt_pkg.
`default_nettype none

module i6flt_core #(
	parameter int unsigned MAX_PACKET_BYTES = i6flt_pkg::MAX_PACKET_BYTES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          step,
	input  wire logic [7:0]                    data_byte,
	input  wire logic                          data_last,
	input  wire logic [63:0]                   addr_upper,
	input  wire logic [63:0]                   addr_lower,
	output i6flt_pkg::result_t                 result
);

	localparam logic [i6flt_pkg::POS_W-1:0] MAX_POS =
		i6flt_pkg::POS_W'(MAX_PACKET_BYTES);
	localparam logic [i6flt_pkg::POS_W-1:0] HDR_POS =
		i6flt_pkg::POS_W'(i6flt_pkg::HEADER_BYTES);
	localparam logic [i6flt_pkg::POS_W-1:0] MIN_POS =
		i6flt_pkg::POS_W'(i6flt_pkg::MIN_PACKET_BYTES);
	localparam logic [i6flt_pkg::POS_W-1:0] DST_LO_POS =
		i6flt_pkg::POS_W'(i6flt_pkg::OFS_DST_START);

	logic [i6flt_pkg::POS_W-1:0] pos_q, pos_next;
	logic [31:0]                 sum_q, sum_next, sum_add;
	logic [3:0]                  version_q, version_next;
	logic                        match_q, match_next;
	logic [7:0]                  nh_q, nh_next;
	logic [15:0]                 port_q, port_next;
	logic [31:0]                 fail_q, fail_next;

	logic                        in_range, in_addr;
	logic [3:0]                  addr_k;
	logic [63:0]                 addr_word;
	logic [7:0]                  addr_exp;
	logic [i6flt_pkg::POS_W-1:0] ul_full;
	logic [15:0]                 ul;
	logic [31:0]                 cks;
	logic [16:0]                 fold1, fold2;
	logic                        cks_ok, is_l4;

	// Field capture and running sum for the byte in hand
	always_comb begin
		in_range = (pos_q < MAX_POS);
		pos_next = (pos_q <= MAX_POS) ? pos_q + 1'b1 : pos_q;

		version_next = (in_range && pos_q == '0) ? data_byte[7:4] : version_q;
		nh_next = (in_range && pos_q == i6flt_pkg::POS_W'(i6flt_pkg::OFS_NEXT_HEADER)) ?
			data_byte : nh_q;

		// Destination address bytes 24..39, byte 24 in the top of the upper word
		addr_k    = {~pos_q[3], pos_q[2:0]};
		addr_word = addr_k[3] ? addr_lower : addr_upper;
		addr_exp  = addr_word[{~addr_k[2:0], 3'b000} +: 8];
		in_addr   = (pos_q >= DST_LO_POS) && (pos_q < HDR_POS);
		match_next = match_q & ~(in_range && in_addr && (data_byte != addr_exp));

		port_next = port_q;
		if (in_range && pos_q == i6flt_pkg::POS_W'(i6flt_pkg::OFS_PORT_HI)) begin
			port_next[15:8] = data_byte;
		end
		if (in_range && pos_q == i6flt_pkg::POS_W'(i6flt_pkg::OFS_PORT_LO)) begin
			port_next[7:0] = data_byte;
		end

		// Even offsets are high bytes of a 16-bit word
		sum_add  = pos_q[0] ? {24'd0, data_byte} : {16'd0, data_byte, 8'd0};
		sum_next = (in_range && pos_q >= i6flt_pkg::POS_W'(i6flt_pkg::OFS_SUM_START)) ?
			sum_q + sum_add : sum_q;
	end

	// Verdict on the final byte, from the updated state
	always_comb begin
		ul_full = pos_next - HDR_POS;
		ul      = ul_full[15:0];
		cks     = sum_next + {16'd0, ul} + {24'd0, nh_next};
		fold1   = {1'b0, cks[15:0]} + {1'b0, cks[31:16]};
		fold2   = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
		cks_ok  = (fold2[15:0] == 16'hFFFF);
		is_l4   = (nh_next == i6flt_pkg::PROTO_TCP) || (nh_next == i6flt_pkg::PROTO_UDP);

		fail_next       = fail_q;
		result.dst_port = 16'd0;
		result.ul_len   = ul;
		result.protocol = nh_next;
		if (pos_next > MAX_POS) begin
			result.verdict = i6flt_pkg::VERDICT_OVERSIZE;
			result.ul_len  = 16'd0;
		end else if (pos_next < MIN_POS || version_next != i6flt_pkg::IP_VERSION) begin
			result.verdict = i6flt_pkg::VERDICT_SHORT;
			result.ul_len  = 16'd0;
		end else if (!match_next) begin
			result.verdict = i6flt_pkg::VERDICT_WRONG_DA;
		end else if (is_l4) begin
			if (!cks_ok) begin
				result.verdict = i6flt_pkg::VERDICT_BAD_CKS;
				fail_next      = fail_q + 32'd1;
			end else begin
				result.verdict = (nh_next == i6flt_pkg::PROTO_TCP) ?
					i6flt_pkg::VERDICT_TCP : i6flt_pkg::VERDICT_UDP;
				result.dst_port = port_next;
			end
		end else begin
			result.verdict = i6flt_pkg::VERDICT_OTHER;
		end
		result.failures = fail_next;
	end

	// Advance per beat; clear packet state after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			sum_q     <= '0;
			version_q <= '0;
			match_q   <= 1'b1;
			nh_q      <= '0;
			port_q    <= '0;
			fail_q    <= '0;
		end else if (step) begin
			if (data_last) begin
				pos_q     <= '0;
				sum_q     <= '0;
				version_q <= '0;
				match_q   <= 1'b1;
				nh_q      <= '0;
				port_q    <= '0;
				fail_q    <= fail_next;
			end else begin
				pos_q     <= pos_next;
				sum_q     <= sum_next;
				version_q <= version_next;
				match_q   <= match_next;
				nh_q      <= nh_next;
				port_q    <= port_next;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/ipv6_ingress_filter_l4_checksum_top.sv -----
// Path: the final byte's beat passes the byte register, then the result register,
// before a verdict is offered.
// Throughput: one byte per cycle; the byte stage stalls only when a final byte
// meets a result still held in the output register.
// Reset: arst_n clears the byte position, the parse state, the failure counter,
// both address registers and all valid flags at once.
// Depends on i6flt_pkg and i6flt_core.
`default_nettype none

module ipv6_ingress_filter_l4_checksum_top #(
	parameter int unsigned MAX_PACKET_BYTES = i6flt_pkg::MAX_PACKET_BYTES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [7:0]                        packet_byte,
	input  wire logic                              last_byte,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [2:0]                             verdict,
	output logic [15:0]                            destination_port,
	output logic [15:0]                            upper_layer_length,
	output logic [7:0]                             protocol_number,
	output logic [31:0]                            checksum_failures,
	input  wire logic                              cfg_write_en,
	input  wire logic [i6flt_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [i6flt_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic               valid_s1, last_s1, advance;
	logic [7:0]         byte_s1;
	logic [63:0]        addr_upper_q, addr_lower_q;
	i6flt_pkg::result_t core_result, result_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_upper_q <= '0;
			addr_lower_q <= '0;
		end else if (cfg_write_en) begin
			case (cfg_index)
				i6flt_pkg::REG_LOCAL_ADDR_UPPER: addr_upper_q <= cfg_data;
				i6flt_pkg::REG_LOCAL_ADDR_LOWER: addr_lower_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Byte stage moves on unless a final byte finds the output register full
	assign advance  = valid_s1 && (!last_s1 || !out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Hold the byte beat
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= packet_byte;
			last_s1 <= last_byte;
		end
	end

	i6flt_core #(
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (byte_s1),
		.data_last (last_s1),
		.addr_upper(addr_upper_q),
		.addr_lower(addr_lower_q),
		.result    (core_result)
	);

	// Result register: load on the final byte, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			result_q <= core_result;
		end
	end

	assign verdict            = result_q.verdict;
	assign destination_port   = result_q.dst_port;
	assign upper_layer_length = result_q.ul_len;
	assign protocol_number    = result_q.protocol;
	assign checksum_failures  = result_q.failures;

endmodule

`default_nettype wire

// ----- hdl/i6flt_checker.sv -----
// Port-level checks on the verdict channel of the ingress filter, bound to the top level.
// Depends on i6flt_pkg.
`default_nettype none

module i6flt_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  verdict,
	input wire logic [15:0] destination_port,
	input wire logic [15:0] upper_layer_length,
	input wire logic [7:0]  protocol_number,
	input wire logic [31:0] checksum_failures
);

	// A stalled verdict beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(verdict)
			&& $stable(checksum_failures))
		else $error("verdict beat changed while stalled");

	// TCP deliveries carry the TCP protocol number
	a_proto: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (verdict == 3'(i6flt_pkg::VERDICT_TCP)) |->
			protocol_number == i6flt_pkg::PROTO_TCP)
		else $error("TCP delivery with wrong protocol");

	// Port only reported on deliveries
	a_port: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (verdict != 3'(i6flt_pkg::VERDICT_TCP))
			&& (verdict != 3'(i6flt_pkg::VERDICT_UDP)) |-> destination_port == 16'd0)
		else $error("port reported on a drop");

	// No length for short or oversize packets
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((verdict == 3'(i6flt_pkg::VERDICT_SHORT))
			|| (verdict == 3'(i6flt_pkg::VERDICT_OVERSIZE))) |-> upper_layer_length == 16'd0)
		else $error("length reported on a short or oversize packet");

	// Failure counter holds between beats unless the later beat is a bad checksum
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready ##1 out_valid
			&& (verdict != 3'(i6flt_pkg::VERDICT_BAD_CKS)) |->
			checksum_failures == $past(checksum_failures))
		else $error("failure counter moved without a checksum drop");

endmodule

bind ipv6_ingress_filter_l4_checksum_top i6flt_checker u_checker (.*);

`default_nettype wire
